[src/pf_pkg.sv]
package pf_pkg;

    localparam int PF_WIDTH         = 31;
    localparam int PF_POS_W         = 5;
    localparam int PF_MAX_RESULTS   = 31;
    localparam int PF_FIRST_DIVISOR = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DECIDE,
        ST_EMIT
    } pf_state_t;

endpackage

[src/prime_factorizer_core.sv]
// Prime factorizer. Each input beat carries one unsigned number; the core answers with its
// prime factors in ascending order, one output beat per factor with repeats, and tlast on
// the final beat of the run. An input of 0 or 1 gives a single beat with factor 0 and the
// no-factor flag in tuser. Trial divisors 2, 3, 4, ... are tried on one shared restoring
// divider that retires one quotient bit per cycle. Trial division ends once the quotient
// drops below the divisor, so a prime near 2^31 takes about 46341 trials; small or smooth
// numbers finish far sooner. The core takes no new input beat until the last result of
// the current one is in the output register; that register lets the next input beat be
// taken while the final result still waits for m_tready.
module prime_factorizer_core #(
    parameter int WIDTH = pf_pkg::PF_WIDTH
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             s_tvalid,
    output logic                                             s_tready,
    // s_tdata fields from bit 0: value
    input  logic [((WIDTH + 7) / 8) * 8 - 1:0]               s_tdata,
    output logic                                             m_tvalid,
    input  logic                                             m_tready,
    // m_tdata fields from bit 0: factor, position
    output logic [((WIDTH + pf_pkg::PF_POS_W + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                             m_tlast,
    // m_tuser fields from bit 0: no_factor
    output logic [0:0]                                       m_tuser
);
    import pf_pkg::*;

    localparam int OUT_W = ((WIDTH + PF_POS_W + 7) / 8) * 8;
    localparam int CNT_W = $clog2(WIDTH);

    pf_state_t state_reg, state_next;

    logic [WIDTH-1:0]    rem_reg, rem_next;
    logic [WIDTH-1:0]    div_reg, div_next;
    logic [PF_POS_W-1:0] k_reg, k_next;
    logic [WIDTH:0]      part_reg, part_next;
    logic [WIDTH-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [WIDTH-1:0]    res_factor_reg, res_factor_next;
    logic                res_last_reg, res_last_next;
    logic                res_none_reg, res_none_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [WIDTH-1:0]    out_factor_reg, out_factor_next;
    logic [PF_POS_W-1:0] out_pos_reg, out_pos_next;
    logic                out_last_reg, out_last_next;
    logic                out_none_reg, out_none_next;

    logic [WIDTH-1:0]    in_value;
    logic                in_fire;
    logic                out_free;
    logic                at_limit;
    logic [WIDTH:0]      part_shift;
    logic [WIDTH:0]      part_diff;
    logic                part_ge;

    assign in_value = s_tdata[WIDTH-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign at_limit = (k_reg == PF_POS_W'(PF_MAX_RESULTS - 1));

    // One restoring division step: bring down the next dividend bit and subtract if it fits.
    assign part_shift = {part_reg[WIDTH-1:0], quo_reg[WIDTH-1]};
    assign part_diff  = part_shift - {1'b0, div_reg};
    assign part_ge    = (part_shift >= {1'b0, div_reg});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (in_value < WIDTH'(2)) ? ST_EMIT : ST_CHECK;
                end
            end
            ST_CHECK:  state_next = at_limit ? ST_EMIT : ST_DIV;
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // quotient < divisor means divisor squared exceeds the remainder.
                if (quo_reg < div_reg || part_reg == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = res_last_reg ? ST_IDLE : ST_CHECK;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        rem_next        = rem_reg;
        div_next        = div_reg;
        k_next          = k_reg;
        part_next       = part_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        res_factor_next = res_factor_reg;
        res_last_next   = res_last_reg;
        res_none_next   = res_none_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_factor_next = out_factor_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        out_none_next   = out_none_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    rem_next        = in_value;
                    div_next        = WIDTH'(PF_FIRST_DIVISOR);
                    k_next          = '0;
                    res_factor_next = '0;
                    res_last_next   = 1'b1;
                    res_none_next   = 1'b1;
                end
            end
            ST_CHECK: begin
                if (at_limit) begin
                    // Result list full: the whole cofactor goes out as the final beat.
                    res_factor_next = rem_reg;
                    res_last_next   = 1'b1;
                    res_none_next   = 1'b0;
                end else begin
                    part_next = '0;
                    quo_next  = rem_reg;
                    cnt_next  = CNT_W'(WIDTH - 1);
                end
            end
            ST_DIV: begin
                part_next = part_ge ? part_diff : part_shift;
                quo_next  = {quo_reg[WIDTH-2:0], part_ge};
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            ST_DECIDE: begin
                res_none_next = 1'b0;
                if (quo_reg < div_reg) begin
                    // The remaining cofactor is prime and above one here.
                    res_factor_next = rem_reg;
                    res_last_next   = 1'b1;
                end else if (part_reg == '0) begin
                    res_factor_next = div_reg;
                    res_last_next   = (quo_reg == WIDTH'(1));
                    rem_next        = quo_reg;
                end else begin
                    div_next = div_reg + WIDTH'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    out_factor_next = res_factor_reg;
                    out_pos_next    = k_reg;
                    out_last_next   = res_last_reg;
                    out_none_next   = res_none_reg;
                    k_next          = k_reg + PF_POS_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        k_reg          <= k_next;
        part_reg       <= part_next;
        quo_reg        <= quo_next;
        cnt_reg        <= cnt_next;
        res_factor_reg <= res_factor_next;
        res_last_reg   <= res_last_next;
        res_none_reg   <= res_none_next;
        out_factor_reg <= out_factor_next;
        out_pos_reg    <= out_pos_next;
        out_last_reg   <= out_last_next;
        out_none_reg   <= out_none_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({out_pos_reg, out_factor_reg});
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_none_reg;

    a_none_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && out_pos_reg == '0 && out_factor_reg == '0))
        else $error("no-factor beat must be a single final beat with factor zero");

    a_factor_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (out_factor_reg >= WIDTH'(2)))
        else $error("a reported factor must be at least two");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("core must be busy after taking an input beat");

    a_div_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE) |-> (part_reg < {1'b0, div_reg}))
        else $error("divider remainder must be below the divisor");

endmodule

[sim/prime_factorizer_core_tb.sv]
`timescale 1ns / 1ps

module prime_factorizer_core_tb;

    import pf_pkg::*;

    localparam int IN_W        = ((PF_WIDTH + 7) / 8) * 8;
    localparam int OUT_W       = ((PF_WIDTH + PF_POS_W + 7) / 8) * 8;
    localparam int HOLD_CYCLES = 400;
    localparam longint unsigned VALUE_MAX = (64'd1 << PF_WIDTH) - 1;

    typedef struct packed {
        logic [PF_WIDTH-1:0] factor;
        logic [PF_POS_W-1:0] position;
        logic                last;
        logic                no_factor;
    } factor_beat_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;
    logic [0:0]        m_tuser;

    factor_beat_t factor_queue[$];
    int           error_count  = 0;
    int           src_idle_pct = 0;
    int           sink_idle_pct = 0;
    int           hold_epoch   = 0;
    int           seen_epoch   = 0;
    int           hold_left    = 0;

    prime_factorizer_core #(
        .WIDTH(PF_WIDTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Works out the factor beats for one number by trial division. A factor found
    // in the loop is the final one exactly when it leaves a cofactor of 1.
    function automatic void push_factors(input logic [PF_WIDTH-1:0] value);
        longint unsigned rem;
        longint unsigned divisor;
        longint unsigned rem_next;
        int              k;
        factor_beat_t    beat;
        rem     = value;
        divisor = PF_FIRST_DIVISOR;
        k       = 0;
        if (rem < 2) begin
            beat = '{factor: '0, position: '0, last: 1'b1, no_factor: 1'b1};
            factor_queue.push_back(beat);
            return;
        end
        while (k < PF_MAX_RESULTS - 1 && divisor * divisor <= rem) begin
            if (rem % divisor == 0) begin
                rem_next = rem / divisor;
                beat = '{factor: divisor[PF_WIDTH-1:0], position: k[PF_POS_W-1:0],
                         last: (rem_next == 1), no_factor: 1'b0};
                factor_queue.push_back(beat);
                k++;
                rem = rem_next;
            end else begin
                divisor++;
            end
        end
        if (rem > 1) begin
            beat = '{factor: rem[PF_WIDTH-1:0], position: k[PF_POS_W-1:0],
                     last: 1'b1, no_factor: 1'b0};
            factor_queue.push_back(beat);
        end
    endfunction

    // Random numbers are kept smooth or small so that trial division stays short:
    // no number here has two prime factors above 255.
    function automatic logic [PF_WIDTH-1:0] random_value();
        longint unsigned v;
        longint unsigned f;
        int              sel;
        sel = $urandom_range(9);
        v   = 1;
        case (sel)
            0: begin
                v = $urandom_range(15);
            end
            1, 2: begin
                v = $urandom_range(65535, 2);
            end
            9: begin
                f = $urandom_range(7, 2);
                v = f;
                while (v * f <= VALUE_MAX && $urandom_range(15) != 0) v = v * f;
            end
            default: begin
                forever begin
                    f = $urandom_range(255, 2);
                    if (v * f > VALUE_MAX) break;
                    v = v * f;
                end
                if (sel == 8) begin
                    f = $urandom_range(65535, 2);
                    if (v * f <= VALUE_MAX) v = v * f;
                end
            end
        endcase
        return v[PF_WIDTH-1:0];
    endfunction

    task automatic send_value(input logic [PF_WIDTH-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(value);
        do @(posedge aclk); while (!s_tready);
        push_factors(value);
    endtask

    task automatic test_no_factor();
        send_value('0);
        send_value(PF_WIDTH'(1));
    endtask

    task automatic test_small_numbers();
        send_value(PF_WIDTH'(2));
        send_value(PF_WIDTH'(3));
        send_value(PF_WIDTH'(4));
        send_value(PF_WIDTH'(49));
        send_value(PF_WIDTH'(63001));
        send_value(PF_WIDTH'(65521));
    endtask

    // Longest factor list, alternating bit patterns and the all-ones prime, which is
    // the slowest number the core can be given.
    task automatic test_wide_values();
        send_value(PF_WIDTH'(1073741824));
        send_value(PF_WIDTH'(1162261467));
        send_value(PF_WIDTH'(223092870));
        send_value(PF_WIDTH'(1431655765));
        send_value(PF_WIDTH'(715827882));
        send_value(PF_WIDTH'(2147483646));
        send_value(PF_WIDTH'(VALUE_MAX));
    endtask

    task automatic test_random(input int count);
        repeat (count) send_value(random_value());
    endtask

    // The receiver stops for a long stretch while short numbers keep coming, so the
    // output register fills and the core has to stall its input.
    task automatic test_backpressure();
        hold_epoch <= hold_epoch + 1;
        repeat (10) send_value(PF_WIDTH'($urandom_range(63)));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_epoch != seen_epoch) begin
            seen_epoch <= hold_epoch;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        factor_beat_t got;
        factor_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{factor: m_tdata[PF_WIDTH-1:0],
                    position: m_tdata[PF_WIDTH +: PF_POS_W],
                    last: m_tlast, no_factor: m_tuser[0]};
            if (factor_queue.size() == 0) begin
                $display("%0t: unexpected beat factor=%0d pos=%0d last=%0b none=%0b",
                         $realtime, got.factor, got.position, got.last, got.no_factor);
                error_count++;
            end else begin
                want = factor_queue.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected factor=%0d pos=%0d last=%0b none=%0b",
                             $realtime, want.factor, want.position, want.last, want.no_factor);
                    $display("%0t:          actual factor=%0d pos=%0d last=%0b none=%0b",
                             $realtime, got.factor, got.position, got.last, got.no_factor);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #250_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct  = 7;
        sink_idle_pct = 80;
        test_no_factor();
        test_small_numbers();
        test_wide_values();
        test_random(35);

        src_idle_pct  = 80;
        sink_idle_pct = 7;
        test_random(35);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_backpressure();
        test_random(25);

        s_tvalid <= 1'b0;
        while (factor_queue.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
src/pf_pkg.sv
src/prime_factorizer_core.sv
sim/prime_factorizer_core_tb.sv
